/* hdl/sgr_pkg.sv */
// Package for the SGR attribute decoder: code points, state layout and
// small helper functions. No dependencies.
`default_nettype none
package sgr_pkg;

  localparam int MAX_PARAMS = 16;

  localparam int VAL_W = 16;
  localparam int CNT_W = 5;
  localparam int POS_W = 5;
  localparam int LIM_W = CNT_W + 1;
  localparam int COL_W = 8;
  localparam int LVL_W = 3;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // SGR code points
  localparam logic [VAL_W-1:0] SGR_RESET     = 16'd0;
  localparam logic [VAL_W-1:0] SGR_BOLD      = 16'd1;
  localparam logic [VAL_W-1:0] SGR_DIM       = 16'd2;
  localparam logic [VAL_W-1:0] SGR_UL        = 16'd4;
  localparam logic [VAL_W-1:0] SGR_REV       = 16'd7;
  localparam logic [VAL_W-1:0] SGR_NORMAL    = 16'd22;
  localparam logic [VAL_W-1:0] SGR_NO_UL     = 16'd24;
  localparam logic [VAL_W-1:0] SGR_NO_REV    = 16'd27;
  localparam logic [VAL_W-1:0] SGR_FG_BASE   = 16'd30;
  localparam logic [VAL_W-1:0] SGR_FG_LAST   = 16'd37;
  localparam logic [VAL_W-1:0] SGR_FG_EXT    = 16'd38;
  localparam logic [VAL_W-1:0] SGR_FG_DEF    = 16'd39;
  localparam logic [VAL_W-1:0] SGR_BG_BASE   = 16'd40;
  localparam logic [VAL_W-1:0] SGR_BG_LAST   = 16'd47;
  localparam logic [VAL_W-1:0] SGR_BG_EXT    = 16'd48;
  localparam logic [VAL_W-1:0] SGR_BG_DEF    = 16'd49;
  localparam logic [VAL_W-1:0] SGR_FG_BRIGHT = 16'd90;
  localparam logic [VAL_W-1:0] SGR_FG_BR_END = 16'd97;
  localparam logic [VAL_W-1:0] SGR_BG_BRIGHT = 16'd100;
  localparam logic [VAL_W-1:0] SGR_BG_BR_END = 16'd107;

  // Selectors following 38/48
  localparam logic [VAL_W-1:0] SEL_INDEX = 16'd5;
  localparam logic [VAL_W-1:0] SEL_RGB   = 16'd2;

  localparam logic [COL_W-1:0] BRIGHT_OFS = 8'd8;
  localparam logic [COL_W-1:0] CUBE_BASE  = 8'd16;
  localparam logic [COL_W-1:0] CUBE_R     = 8'd36;
  localparam logic [COL_W-1:0] CUBE_G     = 8'd6;
  localparam logic [VAL_W-1:0] CHAN_MAX   = 16'd255;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SELECT,
    PH_INDEX,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_t;

  typedef struct packed {
    logic [COL_W-1:0] fore;
    logic [COL_W-1:0] back;
    logic             fg_def;
    logic             bg_def;
    logic             bold;
    logic             dim;
    logic             ul;
    logic             rev;
    phase_t           phase;
    logic             tgt_back;
    logic             rgb_ok;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [POS_W-1:0] pos;
  } sgr_state_t;

  localparam sgr_state_t STATE_RST = '{
    fore: '0, back: '0, fg_def: 1'b1, bg_def: 1'b1, bold: 1'b0, dim: 1'b0,
    ul: 1'b0, rev: 1'b0, phase: PH_IDLE, tgt_back: 1'b0, rgb_ok: 1'b0,
    red: '0, green: '0, pos: '0
  };

  function automatic logic [COL_W-1:0] clamp255(input logic [VAL_W-1:0] v);
    clamp255 = (v > CHAN_MAX) ? CHAN_MAX[COL_W-1:0] : v[COL_W-1:0];
  endfunction

  // floor(min(v,255) * 5 / 255) == floor(min(v,255) / 51)
  function automatic logic [LVL_W-1:0] level_of(input logic [VAL_W-1:0] v);
    if (v >= 16'd255)      level_of = 3'd5;
    else if (v >= 16'd204) level_of = 3'd4;
    else if (v >= 16'd153) level_of = 3'd3;
    else if (v >= 16'd102) level_of = 3'd2;
    else if (v >= 16'd51)  level_of = 3'd1;
    else                   level_of = 3'd0;
  endfunction

endpackage
`default_nettype wire

/* hdl/sgr_next.sv */
// Next-state logic of the SGR decoder: phase tracking for extended colors
// and the ordinary code decode. Depends on sgr_pkg.
`default_nettype none
module sgr_next (
  input  wire logic [sgr_pkg::VAL_W-1:0] value,
  input  wire logic                      first,
  input  wire logic [sgr_pkg::CNT_W-1:0] count,
  input  wire sgr_pkg::sgr_state_t       cur,
  output sgr_pkg::sgr_state_t            nxt
);

  sgr_pkg::phase_t             eff_phase;
  sgr_pkg::phase_t             phase_nxt;
  logic [sgr_pkg::POS_W-1:0]   pos;
  logic [sgr_pkg::LIM_W-1:0]   n_lim;
  logic                        in_range;
  logic                        room2;
  logic                        room4;
  logic                        is_ext;
  logic                        bare;
  logic                        ord_en;
  logic                        set_en;
  logic [sgr_pkg::COL_W-1:0]   set_idx;
  logic                        ld_red;
  logic                        ld_green;
  logic [sgr_pkg::COL_W-1:0]   cube_idx;

  assign eff_phase = first ? sgr_pkg::PH_IDLE : cur.phase;
  assign pos       = first ? '0 : cur.pos;
  assign n_lim     = (sgr_pkg::LIM_W'(count) > sgr_pkg::LIM_W'(sgr_pkg::MAX_PARAMS)) ?
                     sgr_pkg::LIM_W'(sgr_pkg::MAX_PARAMS) : sgr_pkg::LIM_W'(count);
  assign in_range  = sgr_pkg::LIM_W'(pos) < n_lim;
  assign room2     = (sgr_pkg::LIM_W'(pos) + sgr_pkg::LIM_W'(2)) < n_lim;
  assign room4     = (sgr_pkg::LIM_W'(pos) + sgr_pkg::LIM_W'(4)) < n_lim;
  assign is_ext    = (value == sgr_pkg::SGR_FG_EXT) || (value == sgr_pkg::SGR_BG_EXT);

  assign cube_idx = sgr_pkg::CUBE_BASE
                  + sgr_pkg::COL_W'(cur.red) * sgr_pkg::CUBE_R
                  + sgr_pkg::COL_W'(cur.green) * sgr_pkg::CUBE_G
                  + sgr_pkg::COL_W'(sgr_pkg::level_of(value));

  // phase machine: next phase and the action this item takes
  always_comb begin
    phase_nxt = eff_phase;
    bare      = 1'b0;
    ord_en    = 1'b0;
    set_en    = 1'b0;
    set_idx   = sgr_pkg::clamp255(value);
    ld_red    = 1'b0;
    ld_green  = 1'b0;
    if (count == '0) begin
      bare      = 1'b1;
      phase_nxt = sgr_pkg::PH_IDLE;
    end else if (in_range) begin
      unique case (eff_phase)
        sgr_pkg::PH_SELECT: begin
          if (value == sgr_pkg::SEL_INDEX) begin
            phase_nxt = sgr_pkg::PH_INDEX;
          end else if (value == sgr_pkg::SEL_RGB && cur.rgb_ok) begin
            phase_nxt = sgr_pkg::PH_RED;
          end else begin
            // selector falls back to an ordinary code
            ord_en    = 1'b1;
            phase_nxt = (is_ext && room2) ? sgr_pkg::PH_SELECT : sgr_pkg::PH_IDLE;
          end
        end
        sgr_pkg::PH_INDEX: begin
          set_en    = 1'b1;
          phase_nxt = sgr_pkg::PH_IDLE;
        end
        sgr_pkg::PH_RED: begin
          ld_red    = 1'b1;
          phase_nxt = sgr_pkg::PH_GREEN;
        end
        sgr_pkg::PH_GREEN: begin
          ld_green  = 1'b1;
          phase_nxt = sgr_pkg::PH_BLUE;
        end
        sgr_pkg::PH_BLUE: begin
          set_en    = 1'b1;
          set_idx   = cube_idx;
          phase_nxt = sgr_pkg::PH_IDLE;
        end
        default: begin
          ord_en    = 1'b1;
          phase_nxt = (is_ext && room2) ? sgr_pkg::PH_SELECT : sgr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // attribute and color update
  always_comb begin
    nxt       = cur;
    nxt.phase = phase_nxt;
    nxt.pos   = (pos == sgr_pkg::POS_MAX) ? sgr_pkg::POS_MAX : pos + 1'b1;
    if (bare) begin
      nxt.fore   = '0;
      nxt.back   = '0;
      nxt.fg_def = 1'b1;
      nxt.bg_def = 1'b1;
      nxt.bold   = 1'b0;
      nxt.dim    = 1'b0;
      nxt.ul     = 1'b0;
      nxt.rev    = 1'b0;
    end
    if (ld_red)   nxt.red   = sgr_pkg::level_of(value);
    if (ld_green) nxt.green = sgr_pkg::level_of(value);
    if (set_en) begin
      if (cur.tgt_back) begin
        nxt.back   = set_idx;
        nxt.bg_def = 1'b0;
      end else begin
        nxt.fore   = set_idx;
        nxt.fg_def = 1'b0;
      end
    end
    if (ord_en) begin
      unique case (value) inside
        sgr_pkg::SGR_RESET: begin
          nxt.fore   = '0;
          nxt.back   = '0;
          nxt.fg_def = 1'b1;
          nxt.bg_def = 1'b1;
          nxt.bold   = 1'b0;
          nxt.dim    = 1'b0;
          nxt.ul     = 1'b0;
          nxt.rev    = 1'b0;
        end
        sgr_pkg::SGR_BOLD:   nxt.bold   = 1'b1;
        sgr_pkg::SGR_DIM:    nxt.dim    = 1'b1;
        sgr_pkg::SGR_UL:     nxt.ul     = 1'b1;
        sgr_pkg::SGR_REV:    nxt.rev    = 1'b1;
        sgr_pkg::SGR_NORMAL: begin
          nxt.bold = 1'b0;
          nxt.dim  = 1'b0;
        end
        sgr_pkg::SGR_NO_UL:  nxt.ul     = 1'b0;
        sgr_pkg::SGR_NO_REV: nxt.rev    = 1'b0;
        sgr_pkg::SGR_FG_DEF: nxt.fg_def = 1'b1;
        sgr_pkg::SGR_BG_DEF: nxt.bg_def = 1'b1;
        sgr_pkg::SGR_FG_EXT, sgr_pkg::SGR_BG_EXT: begin
          if (room2) begin
            nxt.tgt_back = (value == sgr_pkg::SGR_BG_EXT);
            nxt.rgb_ok   = room4;
          end
        end
        [sgr_pkg::SGR_FG_BASE:sgr_pkg::SGR_FG_LAST]: begin
          nxt.fore   = sgr_pkg::COL_W'(value - sgr_pkg::SGR_FG_BASE);
          nxt.fg_def = 1'b0;
        end
        [sgr_pkg::SGR_FG_BRIGHT:sgr_pkg::SGR_FG_BR_END]: begin
          nxt.fore   = sgr_pkg::COL_W'(value - sgr_pkg::SGR_FG_BRIGHT) + sgr_pkg::BRIGHT_OFS;
          nxt.fg_def = 1'b0;
        end
        [sgr_pkg::SGR_BG_BASE:sgr_pkg::SGR_BG_LAST]: begin
          nxt.back   = sgr_pkg::COL_W'(value - sgr_pkg::SGR_BG_BASE);
          nxt.bg_def = 1'b0;
        end
        [sgr_pkg::SGR_BG_BRIGHT:sgr_pkg::SGR_BG_BR_END]: begin
          nxt.back   = sgr_pkg::COL_W'(value - sgr_pkg::SGR_BG_BRIGHT) + sgr_pkg::BRIGHT_OFS;
          nxt.bg_def = 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/sgr_attribute_decoder_top.sv */
// Top level of the SGR attribute decoder: input register, decoder state
// (which doubles as the result register) and handshake. Uses sgr_pkg, sgr_next.
//
//   channel | ports                                  | role
//   --------+----------------------------------------+----------------------------
//   in      | in_valid/in_ready, value, first, count | one SGR parameter per item
//   out     | out_valid/out_ready, colors, 6 flags   | attribute state after item
//
// One item per cycle sustained while out_ready stays high; a result shows after its item is
// accepted and passes the input register, then the next-state update into the state register.
// Synchronous active-low reset restores default colors and clears the attribute flags.
// A stalled result holds the state register; the input register keeps taking
// one more item, then in_ready drops until out_ready returns.
`default_nettype none
module sgr_attribute_decoder_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sgr_pkg::VAL_W-1:0] in_value,
  input  wire logic                      in_first,
  input  wire logic [sgr_pkg::CNT_W-1:0] in_count,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [sgr_pkg::COL_W-1:0]      out_fg_color,
  output logic [sgr_pkg::COL_W-1:0]      out_bg_color,
  output logic                           out_fg_is_default,
  output logic                           out_bg_is_default,
  output logic                           out_bold,
  output logic                           out_dim,
  output logic                           out_underline,
  output logic                           out_reverse
);

  logic [sgr_pkg::VAL_W-1:0] value_r;
  logic                      first_r;
  logic [sgr_pkg::CNT_W-1:0] count_r;
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  sgr_pkg::sgr_state_t       state_r;
  sgr_pkg::sgr_state_t       state_nxt;
  logic                      in_fire;
  logic                      s1_fire;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r <= in_value;
      first_r <= in_first;
      count_r <= in_count;
    end
  end

  sgr_next u_next (
    .value (value_r),
    .first (first_r),
    .count (count_r),
    .cur   (state_r),
    .nxt   (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= sgr_pkg::STATE_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) state_r <= state_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fg_color      = state_r.fore;
  assign out_bg_color      = state_r.back;
  assign out_fg_is_default = state_r.fg_def;
  assign out_bg_is_default = state_r.bg_def;
  assign out_bold          = state_r.bold;
  assign out_dim           = state_r.dim;
  assign out_underline     = state_r.ul;
  assign out_reverse       = state_r.rev;

endmodule
`default_nettype wire

/* hdl/sgr_checker.sv */
// Port-level checks for the SGR attribute decoder, bound to the top level.
// Uses sgr_pkg widths only.
`default_nettype none
module sgr_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [sgr_pkg::VAL_W-1:0] in_value,
  input wire logic                      in_first,
  input wire logic [sgr_pkg::CNT_W-1:0] in_count,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [sgr_pkg::COL_W-1:0] out_fg_color,
  input wire logic [sgr_pkg::COL_W-1:0] out_bg_color,
  input wire logic                      out_fg_is_default,
  input wire logic                      out_bg_is_default,
  input wire logic                      out_bold,
  input wire logic                      out_dim,
  input wire logic                      out_underline,
  input wire logic                      out_reverse
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fg_color)
      && $stable(out_bg_color) && $stable(out_bold) && $stable(out_reverse))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // reset yields default colors and no pending result
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && out_fg_is_default && out_bg_is_default
      && out_fg_color == '0 && out_bg_color == '0 && !out_bold && !out_dim
      && !out_underline)
    else $error("bad state after reset");

  // color and default-flag state only moves together with a new result
  a_change_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (!$stable(out_fg_color) || !$stable(out_bg_color)
      || !$stable(out_fg_is_default) || !$stable(out_bg_is_default)) |-> out_valid)
    else $error("state changed without a result");

endmodule

bind sgr_attribute_decoder_top sgr_checker u_sgr_checker (.*);
`default_nettype wire

/* verif/sgr_attribute_decoder_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for sgr_attribute_decoder_top: directed and random SGR parameter items,
// each result checked against an in-bench model of the colors and attribute flags.
// Needs sgr_pkg and the decoder RTL.
module sgr_attribute_decoder_top_tb;
  import sgr_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] fg;
    logic [COL_W-1:0] bg;
    logic             fg_def;
    logic             bg_def;
    logic             bold;
    logic             dim;
    logic             ul;
    logic             rev;
  } attr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VAL_W-1:0] in_value = '0;
  logic in_first = 1'b0;
  logic [CNT_W-1:0] in_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COL_W-1:0] out_fg_color, out_bg_color;
  logic out_fg_is_default, out_bg_is_default, out_bold, out_dim, out_underline, out_reverse;

  sgr_attribute_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_value(in_value), .in_first(in_first), .in_count(in_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fg_color(out_fg_color), .out_bg_color(out_bg_color),
    .out_fg_is_default(out_fg_is_default), .out_bg_is_default(out_bg_is_default),
    .out_bold(out_bold), .out_dim(out_dim),
    .out_underline(out_underline), .out_reverse(out_reverse)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state of the decoder
  logic [COL_W-1:0] fore_idx, back_idx;
  logic fg_dflt, bg_dflt, bold_f, dim_f, ul_f, rev_f;
  phase_t ext_phase;
  logic ext_back, ext_rgb_room;
  logic [LVL_W-1:0] red_lvl, green_lvl;
  logic [POS_W-1:0] next_pos;

  attr_result_t attr_expect_q[$];
  int errors = 0;
  bit calm = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  function automatic void default_colors();
    fore_idx = '0;
    back_idx = '0;
    fg_dflt = 1'b1;
    bg_dflt = 1'b1;
    bold_f = 1'b0;
    dim_f = 1'b0;
    ul_f = 1'b0;
    rev_f = 1'b0;
  endfunction

  function automatic void paint(input logic back, input logic [COL_W-1:0] idx);
    if (back) begin
      back_idx = idx;
      bg_dflt = 1'b0;
    end else begin
      fore_idx = idx;
      fg_dflt = 1'b0;
    end
  endfunction

  function automatic logic [COL_W-1:0] sat8(input logic [VAL_W-1:0] v);
    return (v > CHAN_MAX) ? CHAN_MAX[COL_W-1:0] : v[COL_W-1:0];
  endfunction

  function automatic int cube_level(input logic [VAL_W-1:0] v);
    return int'(sat8(v)) * 5 / int'(CHAN_MAX);
  endfunction

  function automatic void plain_code(input logic [VAL_W-1:0] v, input int pos, input int n);
    case (v)
      SGR_RESET:  default_colors();
      SGR_BOLD:   bold_f = 1'b1;
      SGR_DIM:    dim_f = 1'b1;
      SGR_UL:     ul_f = 1'b1;
      SGR_REV:    rev_f = 1'b1;
      SGR_NORMAL: begin
        bold_f = 1'b0;
        dim_f = 1'b0;
      end
      SGR_NO_UL:  ul_f = 1'b0;
      SGR_NO_REV: rev_f = 1'b0;
      SGR_FG_DEF: fg_dflt = 1'b1;
      SGR_BG_DEF: bg_dflt = 1'b1;
      SGR_FG_EXT, SGR_BG_EXT: begin
        // needs the selector and at least one more parameter
        if (pos + 2 < n) begin
          ext_phase = PH_SELECT;
          ext_back = (v == SGR_BG_EXT);
          ext_rgb_room = (pos + 4 < n);
        end
      end
      default: begin
        if (v >= SGR_FG_BASE && v <= SGR_FG_LAST)
          paint(1'b0, COL_W'(v - SGR_FG_BASE));
        else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BR_END)
          paint(1'b0, COL_W'(v - SGR_FG_BRIGHT) + BRIGHT_OFS);
        else if (v >= SGR_BG_BASE && v <= SGR_BG_LAST)
          paint(1'b1, COL_W'(v - SGR_BG_BASE));
        else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BR_END)
          paint(1'b1, COL_W'(v - SGR_BG_BRIGHT) + BRIGHT_OFS);
      end
    endcase
  endfunction

  function automatic attr_result_t predict_attrs(input logic [VAL_W-1:0] v, input logic first,
                                                 input logic [CNT_W-1:0] cnt);
    int n;
    int pos;
    attr_result_t r;
    n = (cnt > MAX_PARAMS) ? MAX_PARAMS : int'(cnt);
    if (first) begin
      pos = 0;
      ext_phase = PH_IDLE;
    end else begin
      pos = int'(next_pos);
    end
    if (cnt == 0) begin
      default_colors();
      ext_phase = PH_IDLE;
    end else if (pos < n) begin
      case (ext_phase)
        PH_SELECT: begin
          if (v == SEL_INDEX) begin
            ext_phase = PH_INDEX;
          end else if (v == SEL_RGB && ext_rgb_room) begin
            ext_phase = PH_RED;
          end else begin
            ext_phase = PH_IDLE;
            plain_code(v, pos, n);
          end
        end
        PH_INDEX: begin
          paint(ext_back, sat8(v));
          ext_phase = PH_IDLE;
        end
        PH_RED: begin
          red_lvl = LVL_W'(cube_level(v));
          ext_phase = PH_GREEN;
        end
        PH_GREEN: begin
          green_lvl = LVL_W'(cube_level(v));
          ext_phase = PH_BLUE;
        end
        PH_BLUE: begin
          paint(ext_back, COL_W'(int'(CUBE_BASE) + int'(CUBE_R) * int'(red_lvl) +
                                 int'(CUBE_G) * int'(green_lvl) + cube_level(v)));
          ext_phase = PH_IDLE;
        end
        default: begin
          ext_phase = PH_IDLE;
          plain_code(v, pos, n);
        end
      endcase
    end
    next_pos = (pos >= int'(POS_MAX)) ? POS_MAX : POS_W'(pos + 1);
    r.fg = fore_idx;
    r.bg = back_idx;
    r.fg_def = fg_dflt;
    r.bg_def = bg_dflt;
    r.bold = bold_f;
    r.dim = dim_f;
    r.ul = ul_f;
    r.rev = rev_f;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // input acceptance feeds the model, output acceptance is checked
  always @(posedge clk) begin
    attr_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        attr_expect_q.push_back(predict_attrs(in_value, in_first, in_count));
      if (out_valid && out_ready) begin
        if (attr_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result with no item pending, expected none, got fg %0d bg %0d",
                   $time, out_fg_color, out_bg_color);
        end else begin
          want = attr_expect_q.pop_front();
          check_field("fg_color", want.fg, out_fg_color);
          check_field("bg_color", want.bg, out_bg_color);
          check_field("fg_is_default", want.fg_def, out_fg_is_default);
          check_field("bg_is_default", want.bg_def, out_bg_is_default);
          check_field("bold", want.bold, out_bold);
          check_field("dim", want.dim, out_dim);
          check_field("underline", want.ul, out_underline);
          check_field("reverse", want.rev, out_reverse);
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 2000) begin
      $display("sgr_attribute_decoder_top_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_param(input logic [VAL_W-1:0] v, input logic first,
                            input logic [CNT_W-1:0] cnt);
    // each cycle idles on its own draw
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_first <= first;
    in_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_seq(input logic [VAL_W-1:0] seq[$], input int cnt, input bit mark);
    foreach (seq[i])
      send_param(seq[i], mark && (i == 0), CNT_W'(cnt));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (attr_expect_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_plain_code();
    case ($urandom_range(13))
      0:  return SGR_RESET;
      1:  return SGR_BOLD;
      2:  return SGR_DIM;
      3:  return SGR_UL;
      4:  return SGR_REV;
      5:  return SGR_NORMAL;
      6:  return SGR_NO_UL;
      7:  return SGR_NO_REV;
      8:  return SGR_FG_DEF;
      9:  return SGR_BG_DEF;
      10: return SGR_FG_BASE + VAL_W'($urandom_range(7));
      11: return SGR_FG_BRIGHT + VAL_W'($urandom_range(7));
      12: return SGR_BG_BASE + VAL_W'($urandom_range(7));
      default: return SGR_BG_BRIGHT + VAL_W'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_channel();
    case ($urandom_range(9))
      0: return VAL_W'($urandom());
      1: begin
        // quantizer and clamp boundaries
        case ($urandom_range(6))
          0: return 16'd0;
          1: return 16'd50;
          2: return 16'd51;
          3: return 16'd254;
          4: return 16'd255;
          5: return 16'd256;
          default: return 16'hFFFF;
        endcase
      end
      default: return VAL_W'($urandom_range(255));
    endcase
  endfunction

  task automatic t_random_sequences(input int budget);
    logic [VAL_W-1:0] seq[$];
    int sent;
    int len;
    int cnt;
    int pick;
    bit big_run;
    sent = 0;
    while (sent < budget) begin
      seq.delete();
      big_run = ($urandom_range(99) < 4);
      len = big_run ? $urandom_range(17, 40) : $urandom_range(1, 8);
      while (seq.size() < len) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          seq.push_back(pick_plain_code());
        end else if (pick < 58) begin
          seq.push_back($urandom_range(1) ? SGR_BG_EXT : SGR_FG_EXT);
          seq.push_back(SEL_INDEX);
          seq.push_back(pick_channel());
        end else if (pick < 76) begin
          seq.push_back($urandom_range(1) ? SGR_BG_EXT : SGR_FG_EXT);
          seq.push_back(SEL_RGB);
          repeat (3) seq.push_back(pick_channel());
        end else if (pick < 88) begin
          seq.push_back(VAL_W'($urandom_range(110)));
        end else begin
          seq.push_back(VAL_W'($urandom()));
        end
      end
      pick = $urandom_range(99);
      if (big_run)
        cnt = $urandom_range(MAX_PARAMS, 31);
      else if (pick < 80)
        cnt = seq.size();
      else if (pick < 92)
        cnt = $urandom_range(0, seq.size());
      else
        cnt = $urandom_range(0, 31);
      // a few sequences run on without a start mark
      send_seq(seq, cnt, $urandom_range(99) >= 4);
      sent += seq.size();
    end
  endtask

  task automatic t_bare_reset();
    send_param(16'hFFFF, 1'b1, '0);
  endtask

  task automatic t_attributes();
    logic [VAL_W-1:0] seq[$];
    // last one is an unknown code
    seq = '{SGR_BOLD, SGR_DIM, SGR_UL, SGR_REV, SGR_FG_LAST, SGR_BG_LAST, 16'hFFFF};
    send_seq(seq, seq.size(), 1'b1);
  endtask

  task automatic t_color_release();
    logic [VAL_W-1:0] seq[$];
    seq = '{SGR_FG_BR_END, SGR_BG_BR_END, SGR_NORMAL, SGR_NO_UL, SGR_NO_REV,
            SGR_FG_DEF, SGR_BG_DEF};
    send_seq(seq, seq.size(), 1'b1);
  endtask

  task automatic t_extended_colors();
    logic [VAL_W-1:0] seq[$];
    seq = '{SGR_FG_EXT, SEL_INDEX, 16'd300, SGR_BG_EXT, SEL_RGB, 16'd255, 16'd128, 16'hFFFF};
    send_seq(seq, seq.size(), 1'b1);
  endtask

  task automatic t_short_extended();
    logic [VAL_W-1:0] seq[$];
    // rgb selector without room falls back to dim; trailing 48 is skipped
    seq = '{SGR_FG_EXT, SEL_RGB, SGR_BG_EXT};
    send_seq(seq, seq.size(), 1'b1);
  endtask

  task automatic t_count_limits();
    logic [VAL_W-1:0] seq[$];
    seq = '{SGR_UL, SGR_REV};
    send_seq(seq, 1, 1'b1);
    seq = '{SGR_BOLD};
    send_seq(seq, 31, 1'b1);
  endtask

  task automatic t_back_to_back();
    calm = 1'b1;
    t_random_sequences(150);
    calm = 1'b0;
  endtask

  task automatic t_output_stall();
    hold_req = 300;
    t_random_sequences(60);
  endtask

  task automatic t_pause_mid_stream();
    t_random_sequences(40);
    drain_results();
    t_random_sequences(40);
  endtask

  initial begin
    default_colors();
    ext_phase = PH_IDLE;
    ext_back = 1'b0;
    ext_rgb_room = 1'b0;
    red_lvl = '0;
    green_lvl = '0;
    next_pos = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    t_bare_reset();
    t_attributes();
    t_color_release();
    t_extended_colors();
    t_short_extended();
    t_count_limits();
    t_back_to_back();
    t_output_stall();
    t_pause_mid_stream();
    t_random_sequences(1400);
    drain_results();
    repeat (10) @(posedge clk);
    if (attr_expect_q.size() != 0) begin
      errors++;
      $display("%0t: results outstanding, expected 0, got %0d", $time, attr_expect_q.size());
    end
    if (errors == 0)
      $display("sgr_attribute_decoder_top_tb OK");
    else
      $display("sgr_attribute_decoder_top_tb NOT OK");
    $finish;
  end

endmodule
